>>> sv/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared constants and the base64 alphabet lookup for the line-wrapping
// base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

  localparam logic [7:0] CharPad      = 8'h3D;  // '='
  localparam logic [7:0] CharNewline  = 8'h0A;
  localparam logic [7:0] WidthMin     = 8'd4;
  localparam logic [7:0] WidthReset   = 8'd72;
  localparam int unsigned NumSymbols  = 4;

  typedef logic [7:0] char_t;

  // Map a 6-bit sextet to its character in the standard alphabet.
  function automatic char_t b64_char(input logic [5:0] v);
    char_t c;
    c = 8'h00;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

>>> sv/base64_encoder_line_wrap.sv
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Streaming base64 encoder with line wrapping and '=' padding.
// ----------------------------------------------------------------------------
// Bytes enter one item per cycle on the input channel while in_ready_o is
// high; final_byte_i marks the last byte of a message. Two bytes of each
// group of three are held internally and produce nothing; the third byte
// (or the final byte) loads four characters into the result buffer, padded
// with '=' for a short final group. A running column counts characters; once
// it reaches the configured line width (values below 4 act as 4) a newline
// is sent right after that character and the column restarts. The column
// also restarts at the end of each message. Each group drains four or five
// characters on the output channel, one per cycle while out_ready_i is high,
// and run_end_o marks the last character of a group. Bytes that only fill
// the hold registers are accepted every cycle, even while the buffer drains;
// a group-completing byte waits in the input register until the buffer
// frees up. Sustained throughput is set by the single-character output port.
// line_width is written through the configuration channel, always ready, and
// takes effect on the next group.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap
  import b64lw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_line_width_i,
  // input bytes
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       final_byte_i,
  // output characters
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       run_end_o
);

  // configuration register
  logic [7:0] line_width_q;
  logic [7:0] width_eff;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // encoder state
  logic [7:0] pend_q [2];
  logic [1:0] pend_cnt_q;
  logic [7:0] col_q;

  // result buffer: four symbols, a newline flag after each
  char_t      sym_q [NumSymbols];
  logic [3:0] nl_q;
  logic [1:0] idx_q;
  logic       nl_phase_q;
  logic       out_vld_q;

  logic       emits;
  logic       out_last;
  logic       out_take;
  logic       buf_free;
  logic       consume;

  logic [7:0] g0, g1, g2;
  char_t      sym_d [NumSymbols];
  logic [3:0] nl_d;
  logic [7:0] col_d;

  assign cfg_ready_o = 1'b1;
  assign width_eff   = (line_width_q < WidthMin) ? WidthMin : line_width_q;

  // A byte completes a group when two are pending or it ends the message.
  assign emits    = (pend_cnt_q == 2'd2) || in_last_q;
  assign out_last = out_vld_q && (idx_q == 2'd3) && (nl_phase_q || !nl_q[3]);
  assign out_take = out_vld_q && out_ready_i;
  assign buf_free = !out_vld_q || (out_ready_i && out_last);
  assign consume  = in_vld_q && (!emits || buf_free);

  assign in_ready_o = !in_vld_q || consume;

  // Gather the group bytes; missing ones read as zero.
  always_comb begin
    g0 = 8'h00;
    g1 = 8'h00;
    g2 = 8'h00;
    case (pend_cnt_q)
      2'd0: begin
        g0 = in_byte_q;
      end
      2'd1: begin
        g0 = pend_q[0];
        g1 = in_byte_q;
      end
      default: begin
        g0 = pend_q[0];
        g1 = pend_q[1];
        g2 = in_byte_q;
      end
    endcase
  end

  // Form the four symbols and walk the column across them.
  always_comb begin
    logic [7:0] c;
    sym_d[0] = b64_char(g0[7:2]);
    sym_d[1] = b64_char({g0[1:0], g1[7:4]});
    sym_d[2] = (pend_cnt_q == 2'd0) ? CharPad : b64_char({g1[3:0], g2[7:6]});
    sym_d[3] = (pend_cnt_q != 2'd2) ? CharPad : b64_char(g2[5:0]);
    c = col_q;
    for (int i = 0; i < NumSymbols; i++) begin
      c = c + 8'd1;
      nl_d[i] = (c >= width_eff);
      if (nl_d[i]) begin
        c = 8'd0;
      end
    end
    col_d = c;
  end

  assign out_valid_o = out_vld_q;
  assign out_char_o  = nl_phase_q ? CharNewline : sym_q[idx_q];
  assign run_end_o   = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= WidthReset;
      in_vld_q     <= 1'b0;
      pend_cnt_q   <= 2'd0;
      col_q        <= 8'd0;
      out_vld_q    <= 1'b0;
      idx_q        <= 2'd0;
      nl_phase_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        line_width_q <= cfg_line_width_i;
      end

      // hold or refill the input register
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end

      // drain the result buffer
      if (out_take) begin
        if (out_last) begin
          out_vld_q <= 1'b0;
        end else if (!nl_phase_q && nl_q[idx_q]) begin
          nl_phase_q <= 1'b1;
        end else begin
          nl_phase_q <= 1'b0;
          idx_q      <= idx_q + 2'd1;
        end
      end

      if (consume) begin
        if (emits) begin
          // load a new group, clear pending bytes
          out_vld_q  <= 1'b1;
          idx_q      <= 2'd0;
          nl_phase_q <= 1'b0;
          pend_cnt_q <= 2'd0;
          col_q      <= in_last_q ? 8'd0 : col_d;
        end else begin
          pend_cnt_q <= pend_cnt_q + 2'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= final_byte_i;
    end
    if (consume && !emits) begin
      pend_q[pend_cnt_q[0]] <= in_byte_q;
    end
    if (consume && emits) begin
      for (int i = 0; i < NumSymbols; i++) begin
        sym_q[i] <= sym_d[i];
      end
      nl_q <= nl_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pend_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd3)
    else $error("pending byte count out of range");

  a_col_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != 8'hFF)
    else $error("column counter reached 255");

  a_nl_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && nl_phase_q |-> nl_q[idx_q])
    else $error("newline sent where none was scheduled");

  a_msg_end_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> col_q == 8'd0 && pend_cnt_q == 2'd0)
    else $error("column or pending bytes not cleared at message end");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i && in_vld_q && emits |=> in_vld_q)
    else $error("group loaded while result buffer busy");

endmodule

>>> tb/tb_base64_encoder_line_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_encoder_line_wrap
// Self-checking bench for the streaming base64 encoder with line wrapping.
// ----------------------------------------------------------------------------
// Bytes go in through the input channel and every character that comes out
// is checked in order against a local encoder that tracks held bytes, the
// output column and the line width. Directed messages cover padding, the
// alphabet extremes, narrow lines and a width change in mid message. Random
// messages then run under several line widths and three idle patterns on
// the two channels.
// ----------------------------------------------------------------------------
module tb_base64_encoder_line_wrap;
  import b64lw_pkg::*;

  // Cycles to let pass after the last expected character before touching
  // the line width or ending the run; covers a byte still being held.
  localparam int unsigned DrainCycles = 16;

  localparam logic [8*64-1:0] Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    char_t code;
    logic  run_end;
  } enc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_line_width_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       run_end_o;

  // Encoder state mirrored on the bench side.
  logic [7:0] line_width;
  logic [7:0] held_bytes [2];
  int         held_cnt;
  logic [7:0] line_col;

  // Characters the block still owes us, oldest first.
  enc_char_t  encoded_chars [$];

  int         mismatch_cnt = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;

  base64_encoder_line_wrap dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_line_width_i (cfg_line_width_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_byte_i        (in_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .run_end_o        (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  // Map a sextet to its character of the standard alphabet.
  function automatic char_t sextet_char(input logic [5:0] v);
    return Alphabet[8*(63 - v) +: 8];
  endfunction

  // Advance the local encoder by one accepted byte and queue every character
  // it causes. Hold the byte if it neither completes a group nor ends the
  // message.
  task automatic encode_byte(input logic [7:0] b, input logic is_last);
    logic [7:0] g0, g1, g2;
    char_t      sym [4];
    char_t      outc [5];
    logic [7:0] eff_w;
    int         n;
    int         k;
    if (!is_last && held_cnt < 2) begin
      held_bytes[held_cnt[0]] = b;
      held_cnt++;
    end else begin
      g0 = 8'h00;
      g1 = 8'h00;
      g2 = 8'h00;
      case (held_cnt)
        0: begin
          g0 = b;
        end
        1: begin
          g0 = held_bytes[0];
          g1 = b;
        end
        default: begin
          g0 = held_bytes[0];
          g1 = held_bytes[1];
          g2 = b;
        end
      endcase
      n = held_cnt + 1;
      sym[0] = sextet_char(g0[7:2]);
      sym[1] = sextet_char({g0[1:0], g1[7:4]});
      sym[2] = (n < 2) ? CharPad : sextet_char({g1[3:0], g2[7:6]});
      sym[3] = (n < 3) ? CharPad : sextet_char(g2[5:0]);
      // Widths below the minimum act as the minimum.
      eff_w = (line_width < WidthMin) ? WidthMin : line_width;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        outc[k[2:0]] = sym[i];
        k++;
        line_col = line_col + 8'd1;
        // Compare with >= so that a width lowered mid message still wraps.
        if (line_col >= eff_w) begin
          line_col = 8'd0;
          outc[k[2:0]] = CharNewline;
          k++;
        end
      end
      for (int i = 0; i < k; i++) begin
        encoded_chars = {encoded_chars, enc_char_t'({outc[i], (i == k - 1)})};
      end
      held_cnt = 0;
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      // A new message starts on a fresh line count.
      if (is_last) begin
        line_col = 8'd0;
      end
    end
  endtask

  // Offer one byte; hold valid and payload until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    in_byte_i    = b;
    final_byte_i = is_last;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    encode_byte(b, is_last);
  endtask

  // Drop valid, wait for every owed character, then let the block settle.
  task automatic wait_drained;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (encoded_chars.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [7:0] w);
    @(negedge clk_i);
    cfg_valid_i      = 1'b1;
    cfg_line_width_i = w;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    line_width = w;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Messages ending after one or two bytes: both pad shapes, run at the
  // width that reset leaves.
  task automatic test_short_groups;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Complete groups: the all-ones and '+' symbols, a final byte that closes
  // a full group, and a final byte that opens a new group.
  task automatic test_full_groups;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);
  endtask

  // Widths below four, the minimum itself, and a width lowered while a
  // message is open so that the column already sits at it.
  task automatic test_narrow_lines;
    wait_drained();
    write_width(8'd0);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_drained();
    write_width(8'd3);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    wait_drained();
    write_width(WidthReset);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    wait_drained();
    write_width(WidthMin);
    send_byte(8'h7F, 1'b1);
  endtask

  // Random messages in segments, each under its own line width. Messages
  // may stay open across a width change. One segment runs a single long
  // message at the widest setting so the column reaches 255.
  task automatic test_random_messages;
    logic [7:0] seg_width [8];
    logic [7:0] data;
    int         nbytes;
    seg_width = '{8'd9, 8'd4, WidthReset, 8'd255, 8'd0, 8'd0, 8'd0, 8'd5};
    seg_width[5] = 8'($urandom_range(24, 4));
    seg_width[6] = 8'($urandom_range(255, 4));
    for (int seg = 0; seg < 8; seg++) begin
      // Sender mostly busy, receiver mostly stalled; then the reverse; then
      // both at full rate.
      if (seg < 3) begin
        snd_idle_pct = 9;
        rcv_idle_pct = 62;
      end else if (seg < 6) begin
        snd_idle_pct = 62;
        rcv_idle_pct = 9;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      wait_drained();
      write_width(seg_width[seg]);
      nbytes = (seg == 3) ? 192 : 14;
      for (int i = 0; i < nbytes; i++) begin
        if ($urandom_range(7) == 0) begin
          data = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
        end else begin
          data = 8'($urandom);
        end
        if (seg == 3) begin
          send_byte(data, i == nbytes - 1);
        end else begin
          send_byte(data, $urandom_range(2) == 0);
        end
      end
    end
  endtask

  // Stall the character channel at random on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare every accepted character with the oldest one still owed.
  always @(posedge clk_i) begin : check_chars
    enc_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (encoded_chars.size() == 0) begin
        $error("out_char unexpected: expected none, got %h", out_char_o);
        mismatch_cnt++;
      end else begin
        want = encoded_chars.pop_front();
        if (out_char_o !== want.code) begin
          $error("out_char mismatch: expected %h, got %h", want.code, out_char_o);
          mismatch_cnt++;
        end
        if (run_end_o !== want.run_end) begin
          $error("run_end mismatch: expected %b, got %b", want.run_end, run_end_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_line_width_i = 8'h00;
    in_valid_i       = 1'b0;
    in_byte_i        = 8'h00;
    final_byte_i     = 1'b0;
    out_ready_i      = 1'b0;
    line_width       = WidthReset;
    held_bytes[0]    = 8'h00;
    held_bytes[1]    = 8'h00;
    held_cnt         = 0;
    line_col         = 8'd0;
    snd_idle_pct     = 9;
    rcv_idle_pct     = 62;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_short_groups();
    test_full_groups();
    test_narrow_lines();
    test_random_messages();

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run; far beyond the slowest correct one.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
